// File: rtl/udsn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udsn_pkg
// shared constants, types and control structs of the dot-segment normalizer
// ----------------------------------------------------------------------------
package udsn_pkg;

    localparam int PATH_LIMIT  = 4096;
    localparam int STACK_DEPTH = 32;

    localparam int FIELD_W   = 12;
    localparam int POS_W     = FIELD_W + 1;
    localparam int FIELD_MAX = (1 << FIELD_W) - 1;
    localparam int POS_SAT   = 1 << FIELD_W;
    localparam int ADDR_W    = $clog2(STACK_DEPTH);
    localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int TOTAL_W   = FIELD_W + 1;
    localparam int CFG_ADDR_W = 3;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [CFG_ADDR_W-3:0] REG_ROOT_LENGTH = '0;

    typedef enum logic [1:0] {
        DOT_OTHER,
        DOT_ONE,
        DOT_TWO
    } t_dot;

    typedef enum logic [2:0] {
        ST_BYTES,
        ST_SUM,
        ST_SUM_END,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic take;        // byte transfer this cycle
        logic sum_rd;      // read stack entry for the length sum
        logic emit_rd;     // read stack entry for a descriptor
        logic load_seg;    // load segment descriptor into output register
        logic load_empty;  // load the empty-path descriptor
        logic idx_clr;
        logic idx_inc;
        logic clear;       // return path state to its reset values
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage : udsn_pkg
`default_nettype wire

// File: rtl/udsn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udsn_ctrl
// sequencer: byte intake, length-sum pass and descriptor emission pass
// ----------------------------------------------------------------------------
module udsn_ctrl
    import udsn_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_end_of_path,
    input  wire t_status i_status,
    output logic         o_ready,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BYTES;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_BYTES: begin
                if (i_valid && i_end_of_path) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (i_status.count_zero) begin
                    n_state = ST_EMPTY;
                end else if (i_status.idx_last) begin
                    n_state = ST_SUM_END;
                end
            end
            ST_SUM_END: begin
                n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? ST_BYTES : ST_EMIT_RD;
                end
            end
            ST_EMPTY: begin
                if (i_status.out_free) begin
                    n_state = ST_BYTES;
                end
            end
            default: begin
                n_state = ST_BYTES;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_BYTES: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
            end
            ST_SUM: begin
                if (!i_status.count_zero) begin
                    o_cmd.sum_rd = 1'b1;
                    if (i_status.idx_last) begin
                        o_cmd.idx_clr = 1'b1;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_SUM_END: begin
            end
            ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
            end
            ST_EMIT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.load_seg = 1'b1;
                    if (i_status.idx_last) begin
                        o_cmd.clear   = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.load_empty = 1'b1;
                    o_cmd.clear      = 1'b1;
                    o_cmd.idx_clr    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule : udsn_ctrl
`default_nettype wire

// File: rtl/udsn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udsn_datapath
// segment scanner, segment stack memory, length accumulator, output register
// ----------------------------------------------------------------------------
module udsn_datapath
    import udsn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [7:0]         i_path_byte,
    input  wire logic               i_end_of_path,
    input  wire logic [FIELD_W-1:0] i_root_length,
    input  wire logic               i_ready,
    output t_status                 o_status,
    output logic                    o_valid,
    output logic [FIELD_W-1:0]      o_segment_offset,
    output logic [FIELD_W-1:0]      o_segment_length,
    output logic                    o_no_segments,
    output logic                    o_too_long,
    output logic                    o_stack_overflow,
    output logic                    o_last_segment
);

    // path scan state
    logic [POS_W-1:0]   r_pos;
    logic [FIELD_W-1:0] r_start;
    logic               r_prev_slash;
    t_dot               r_dot;
    logic [COUNT_W-1:0] r_count;
    logic               r_overflow;
    logic               r_url_long;

    // stack memory: {offset, length}
    logic [2*FIELD_W-1:0] r_stack [STACK_DEPTH];
    logic [2*FIELD_W-1:0] r_rd_word;
    logic [ADDR_W-1:0]    r_idx;
    logic                 r_acc_en;
    logic [TOTAL_W-1:0]   r_total;

    logic [FIELD_W-1:0] n_start;
    t_dot               n_dot;
    logic               w_pos_nz;
    logic               w_is_slash;
    logic               w_is_dot;
    logic               w_close_mid;
    logic               w_close;
    logic [POS_W-1:0]   w_end;
    logic [POS_W-1:0]   w_start_ext;
    logic [POS_W-1:0]   w_len_raw;
    logic [FIELD_W-1:0] w_len;
    logic               w_drop;
    logic               w_pop;
    logic               w_full;
    logic [TOTAL_W:0]   w_sum;
    logic               w_tl;

    assign w_pos_nz    = (r_pos != '0);
    assign w_is_slash  = (i_path_byte == CH_SLASH);
    assign w_is_dot    = (i_path_byte == CH_DOT);
    assign w_close_mid = w_is_slash && !r_prev_slash;
    assign w_close     = i_cmd.take && w_pos_nz
                         && (w_close_mid || (i_end_of_path && !w_is_slash));
    assign w_full      = (r_count >= COUNT_W'(STACK_DEPTH));

    always_comb begin
        n_start = r_start;
        n_dot   = r_dot;
        if (!w_is_slash) begin
            if (r_prev_slash) begin
                n_start = (r_pos > POS_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
                                                     : r_pos[FIELD_W-1:0];
                n_dot   = w_is_dot ? DOT_ONE : DOT_OTHER;
            end else begin
                n_dot   = (r_dot == DOT_ONE && w_is_dot) ? DOT_TWO : DOT_OTHER;
            end
        end
    end

    // segment end and length
    always_comb begin
        if (w_close_mid) begin
            w_end = r_pos;
        end else if (r_pos >= POS_W'(POS_SAT)) begin
            w_end = POS_W'(POS_SAT);
        end else begin
            w_end = r_pos + POS_W'(1);
        end
        w_start_ext = {1'b0, n_start};
        w_len_raw   = (w_end > w_start_ext) ? (w_end - w_start_ext) : '0;
        w_len       = (w_len_raw > POS_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
                                                     : w_len_raw[FIELD_W-1:0];
        w_drop      = (n_dot == DOT_ONE) && (w_len == FIELD_W'(1));
        w_pop       = (n_dot == DOT_TWO) && (w_len == FIELD_W'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pos        <= '0;
            r_start      <= FIELD_W'(1);
            r_prev_slash <= 1'b1;
            r_dot        <= DOT_OTHER;
            r_count      <= '0;
            r_overflow   <= 1'b0;
        end else if (i_cmd.take) begin
            if (w_pos_nz) begin
                r_start      <= n_start;
                r_dot        <= n_dot;
                r_prev_slash <= w_is_slash;
            end
            if (w_close && !w_drop) begin
                if (w_pop) begin
                    if (r_count != '0) begin
                        r_count <= r_count - COUNT_W'(1);
                    end
                end else if (w_full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            if (!i_end_of_path && r_pos < POS_W'(POS_SAT)) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    // stack write on push, registered read for sum and emission
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && w_close && !w_drop && !w_pop && !w_full) begin
            r_stack[r_count[ADDR_W-1:0]] <= {n_start, w_len};
        end
        if (i_cmd.sum_rd || i_cmd.emit_rd) begin
            r_rd_word <= r_stack[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
    end

    // saturating length sum, seeded with the root length
    assign w_sum = {1'b0, r_total} + (TOTAL_W + 1)'(1)
                   + (TOTAL_W + 1)'(r_rd_word[FIELD_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.sum_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_end_of_path) begin
            r_total    <= TOTAL_W'(i_root_length);
            r_url_long <= (r_pos >= POS_W'(POS_SAT));
        end else if (r_acc_en) begin
            r_total <= (w_sum >= (TOTAL_W + 1)'(PATH_LIMIT)) ? TOTAL_W'(PATH_LIMIT)
                                                             : w_sum[TOTAL_W-1:0];
        end
    end

    assign w_tl = r_url_long || (r_total >= TOTAL_W'(PATH_LIMIT));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_seg || i_cmd.load_empty) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seg) begin
            o_segment_offset <= r_rd_word[2*FIELD_W-1:FIELD_W];
            o_segment_length <= r_rd_word[FIELD_W-1:0];
            o_no_segments    <= 1'b0;
            o_too_long       <= w_tl;
            o_stack_overflow <= r_overflow;
            o_last_segment   <= o_status.idx_last;
        end else if (i_cmd.load_empty) begin
            o_segment_offset <= '0;
            o_segment_length <= '0;
            o_no_segments    <= 1'b1;
            o_too_long       <= w_tl;
            o_stack_overflow <= r_overflow;
            o_last_segment   <= 1'b1;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.idx_last   = ((COUNT_W'(r_idx) + COUNT_W'(1)) == r_count);
    assign o_status.out_free   = !o_valid || i_ready;

endmodule : udsn_datapath
`default_nettype wire

// File: rtl/url_path_dot_segment_normalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// url_path_dot_segment_normalizer_top
// removes dot segments from a url path and emits the kept segments
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  path in   | i_valid / o_ready  | i_path_byte, i_end_of_path
//  segs out  | o_valid / i_ready  | o_segment_offset, o_segment_length, flags
//  config    | apb psel/penable   | root_length at byte address 0
//
//  path bytes are taken one per cycle while no end of path is pending
//  after the final byte: one sum pass over the N kept segments, then a
//  read and a load per descriptor from the single-port segment stack;
//  an empty path loads the empty-path descriptor instead
//  the next path is taken as soon as the last descriptor is loaded, while
//  it may still wait in the output register
//  reset is synchronous, active low; the stack memory needs no clearing
//  since only entries below the stack count are read
//
module url_path_dot_segment_normalizer_top
    import udsn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // path byte channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_path_byte,
    input  wire logic                  i_end_of_path,
    // segment descriptor channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [FIELD_W-1:0]         o_segment_offset,
    output logic [FIELD_W-1:0]         o_segment_length,
    output logic                       o_no_segments,
    output logic                       o_too_long,
    output logic                       o_stack_overflow,
    output logic                       o_last_segment,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_cmd               w_cmd;
    t_status            w_status;
    logic [FIELD_W-1:0] r_root_length;
    logic               w_reg_hit;

    // register decode: word index from the upper address bits
    assign w_reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_ROOT_LENGTH);
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? {{(32 - FIELD_W){1'b0}}, r_root_length} : '0;

    // write on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_length <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_root_length <= pwdata[FIELD_W-1:0];
        end
    end

    // sequencer
    udsn_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_end_of_path (i_end_of_path),
        .i_status      (w_status),
        .o_ready       (o_ready),
        .o_cmd         (w_cmd)
    );

    // scanner, stack and output register
    udsn_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_path_byte      (i_path_byte),
        .i_end_of_path    (i_end_of_path),
        .i_root_length    (r_root_length),
        .i_ready          (i_ready),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_segment_offset (o_segment_offset),
        .o_segment_length (o_segment_length),
        .o_no_segments    (o_no_segments),
        .o_too_long       (o_too_long),
        .o_stack_overflow (o_stack_overflow),
        .o_last_segment   (o_last_segment)
    );

    // the final byte of a path stops intake for at least the next cycle
    a_end_stops_intake : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_end_of_path) |=> !o_ready
    ) else $error("path intake continued after end of path");

    // a run is still being emitted while a non-final descriptor waits
    a_run_blocks_intake : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_segment) |-> !o_ready
    ) else $error("path intake open in the middle of a descriptor run");

    // the empty-path descriptor is a single, zero descriptor
    a_empty_descriptor : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_segments) |->
            (o_last_segment && o_segment_length == '0 && o_segment_offset == '0)
    ) else $error("malformed empty-path descriptor");

endmodule : url_path_dot_segment_normalizer_top
`default_nettype wire

// File: verif/tb_url_path_dot_segment_normalizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_url_path_dot_segment_normalizer_top
// self-checking bench for the url path dot-segment normalizer
//
// feeds url paths one byte per transfer with random bursts and gaps, stalls
// the descriptor side on a rotating pattern and checks every descriptor
// against a cycle-free model of the segment stack; root_length is rewritten
// between phases, including its extremes, and read back over the apb port
// ----------------------------------------------------------------------------
module tb_url_path_dot_segment_normalizer_top;
    import udsn_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;     // idle cycles before a register write
    localparam int TAIL_CYCLES    = 40;    // drain time at the very end
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer at all
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_BYTES    = 32;    // random path bytes per phase
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 24;

    // root_length sits at byte address 0, the next word is unmapped
    localparam logic [CFG_ADDR_W-1:0] ROOT_ADDR  = {REG_ROOT_LENGTH, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {1'b1, 2'b00};

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    // one segment descriptor as it leaves the block
    typedef struct packed {
        logic [FIELD_W-1:0] seg_off;
        logic [FIELD_W-1:0] seg_len;
        logic               no_seg;
        logic               too_long;
        logic               ovf;
        logic               last_seg;
    } seg_desc_t;

    // directed row: one path byte, with a hand-written descriptor where the
    // outcome is obvious (the whole run is then that single descriptor)
    typedef struct packed {
        logic [7:0] byte_val;
        logic       eop;
        logic       typed;
        seg_desc_t  want;
    } dir_row_t;

    localparam seg_desc_t EMPTY_RUN = '{seg_off: '0, seg_len: '0, no_seg: 1'b1,
                                        too_long: 1'b0, ovf: 1'b0, last_seg: 1'b1};
    localparam seg_desc_t ONE_SEG_RUN = '{seg_off: 12'd1, seg_len: 12'd2, no_seg: 1'b0,
                                          too_long: 1'b0, ovf: 1'b0, last_seg: 1'b1};

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // lone leading byte, nothing after it
        '{CH_SLASH,   1'b1, 1'b1, EMPTY_RUN},
        // "/./../" : dot dropped, dot-dot pops an empty stack, trailing slash
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_SLASH,   1'b1, 1'b1, EMPTY_RUN},
        // "/a/.../b" : three dots is an ordinary segment
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_LOWER_A, 1'b0, 1'b0, '0},
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_LOWER_B, 1'b1, 1'b0, '0},
        // "//x/.." : empty segment skipped, dot-dot on the last byte pops x
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_LOWER_X, 1'b0, 1'b0, '0},
        '{CH_SLASH,   1'b0, 1'b0, '0},
        '{CH_DOT,     1'b0, 1'b0, '0},
        '{CH_DOT,     1'b1, 1'b1, EMPTY_RUN},
        // byte extremes, and a first byte that is not a slash
        '{8'hFF,      1'b0, 1'b0, '0},
        '{8'h00,      1'b0, 1'b0, '0},
        '{8'hFF,      1'b1, 1'b1, ONE_SEG_RUN}
    };

    // ------------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [7:0]            i_path_byte;
    logic                  i_end_of_path;
    logic                  o_valid;
    logic                  i_ready;
    logic [FIELD_W-1:0]    o_segment_offset;
    logic [FIELD_W-1:0]    o_segment_length;
    logic                  o_no_segments;
    logic                  o_too_long;
    logic                  o_stack_overflow;
    logic                  o_last_segment;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    url_path_dot_segment_normalizer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_path_byte      (i_path_byte),
        .i_end_of_path    (i_end_of_path),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_segment_offset (o_segment_offset),
        .o_segment_length (o_segment_length),
        .o_no_segments    (o_no_segments),
        .o_too_long       (o_too_long),
        .o_stack_overflow (o_stack_overflow),
        .o_last_segment   (o_last_segment),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // segment stack model: state of the path walker plus the root register
    // ------------------------------------------------------------------------
    logic [FIELD_W-1:0] root_len;
    int                 byte_pos;      // saturates at POS_SAT
    int                 seg_start;
    bit                 prev_slash;
    t_dot               dot_state;
    logic [FIELD_W-1:0] stk_off [STACK_DEPTH];
    logic [FIELD_W-1:0] stk_len [STACK_DEPTH];
    int                 stk_cnt;
    bit                 ovf_seen;

    seg_desc_t          seg_expect_q [$];   // descriptors still to come out
    logic [7:0]         path_q [$];         // bytes of the path being built

    // bookkeeping
    int mismatches;
    int paths_sent;
    int bytes_sent;
    int descs_seen;
    int ovf_runs;
    int too_long_runs;
    int url_long_runs;
    int root_settings;
    int idle_cycles;

    // sender pacing and receiver stall pattern
    int          burst_left;
    int          gap_max;
    logic [15:0] stall_pat;
    logic [3:0]  stall_ph;

    function void clear_path();
        byte_pos   = 0;
        seg_start  = 1;
        prev_slash = 1'b1;
        dot_state  = DOT_OTHER;
        stk_cnt    = 0;
        ovf_seen   = 1'b0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            stk_off[k] = '0;
            stk_len[k] = '0;
        end
    endfunction

    // a segment ends just before end_pos: drop it, pop for it, or push it
    function void close_segment(input int end_pos);
        int len;
        len = (end_pos > seg_start) ? end_pos - seg_start : 0;
        if (len > FIELD_MAX)
            len = FIELD_MAX;
        if (dot_state == DOT_ONE && len == 1)
            return;
        if (dot_state == DOT_TWO && len == 2) begin
            if (stk_cnt > 0)
                stk_cnt--;
            return;
        end
        if (stk_cnt < STACK_DEPTH) begin
            stk_off[stk_cnt] = seg_start[FIELD_W-1:0];
            stk_len[stk_cnt] = len[FIELD_W-1:0];
            stk_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    // end of path: one descriptor per kept segment, or the empty descriptor
    function void queue_descriptors(input bit url_long);
        int        total;
        seg_desc_t d;
        total = root_len;
        for (int k = 0; k < stk_cnt; k++)
            total += 1 + stk_len[k];
        d.too_long = url_long || (total >= PATH_LIMIT);
        d.ovf      = ovf_seen;
        ovf_runs      += ovf_seen;
        too_long_runs += d.too_long;
        url_long_runs += url_long;
        if (stk_cnt == 0) begin
            d.seg_off  = '0;
            d.seg_len  = '0;
            d.no_seg   = 1'b1;
            d.last_seg = 1'b1;
            seg_expect_q.push_back(d);
        end else begin
            for (int k = 0; k < stk_cnt; k++) begin
                d.seg_off  = stk_off[k];
                d.seg_len  = stk_len[k];
                d.no_seg   = 1'b0;
                d.last_seg = (k == stk_cnt - 1);
                seg_expect_q.push_back(d);
            end
        end
    endfunction

    // advance the model by one accepted path byte
    function void walk_byte(input logic [7:0] b, input logic eop);
        int pos;
        bit url_long;
        bit slash;
        pos      = byte_pos;
        url_long = (pos >= POS_SAT);
        if (pos != 0) begin
            slash = (b == CH_SLASH);
            if (!slash) begin
                if (prev_slash) begin
                    seg_start = (pos > FIELD_MAX) ? FIELD_MAX : pos;
                    dot_state = (b == CH_DOT) ? DOT_ONE : DOT_OTHER;
                end else begin
                    dot_state = (dot_state == DOT_ONE && b == CH_DOT) ? DOT_TWO : DOT_OTHER;
                end
            end else if (!prev_slash) begin
                close_segment(pos);
            end
            prev_slash = slash;
            // a path that ends inside a segment closes it one past the last byte
            if (eop && !slash)
                close_segment((pos + 1 > POS_SAT) ? POS_SAT : pos + 1);
        end
        if (eop) begin
            queue_descriptors(url_long);
            clear_path();
        end else if (byte_pos < POS_SAT) begin
            byte_pos++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // path byte driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic eop, input bit typed,
                             input seg_desc_t want);
        int gap;
        int depth_before;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_path_byte   <= b;
        i_end_of_path <= eop;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        depth_before = seg_expect_q.size();
        walk_byte(b, eop);
        // a hand-written row replaces what the model queued for this run
        if (typed) begin
            while (seg_expect_q.size() > depth_before)
                void'(seg_expect_q.pop_back());
            seg_expect_q.push_back(want);
        end
        bytes_sent++;
        paths_sent += eop;
    endtask

    task automatic send_path();
        for (int i = 0; i < path_q.size(); i++)
            push_byte(path_q[i], (i == path_q.size() - 1), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // path generator
    // ------------------------------------------------------------------------
    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0)
            b = 8'($urandom_range(CH_LOWER_A, CH_LOWER_A + 25));
        else
            b = 8'($urandom_range(0, 255));
        // keep names whole, slashes come from the structure
        return (b == CH_SLASH) ? CH_DOT : b;
    endfunction

    function automatic void add_name(input int len);
        for (int i = 0; i < len; i++)
            path_q.push_back(name_byte());
    endfunction

    task automatic build_path(input bit very_long);
        int kind;
        int nseg;
        int len;
        path_q.delete();
        kind = $urandom_range(0, 99);
        if (very_long) begin
            // runs past the 4096-byte position: offsets and lengths clamp
            path_q.push_back(CH_SLASH);
            len = $urandom_range(POS_SAT, POS_SAT + 200);
            for (int i = 0; i < len; i++)
                path_q.push_back(($urandom_range(0, 99) == 0) ? CH_SLASH : name_byte());
        end else if (kind < 8) begin
            // more segments than the stack holds, then a few pops
            nseg = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 8);
            for (int s = 0; s < nseg; s++) begin
                path_q.push_back(CH_SLASH);
                add_name($urandom_range(1, 3));
            end
            repeat ($urandom_range(0, 3)) begin
                path_q.push_back(CH_SLASH);
                path_q.push_back(CH_DOT);
                path_q.push_back(CH_DOT);
            end
        end else if (kind < 20) begin
            // noise rich in slashes and dots, first byte anything
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 2))
                    0:       path_q.push_back(CH_SLASH);
                    1:       path_q.push_back(CH_DOT);
                    default: path_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            // well-formed path of mixed tokens
            nseg = $urandom_range(0, 10);
            if (nseg == 0)
                path_q.push_back(CH_SLASH);
            for (int s = 0; s < nseg; s++) begin
                path_q.push_back(CH_SLASH);
                case ($urandom_range(0, 9))
                    0: ;                                   // empty segment
                    1: path_q.push_back(CH_DOT);
                    2: begin
                        path_q.push_back(CH_DOT);
                        path_q.push_back(CH_DOT);
                    end
                    3: repeat (3) path_q.push_back(CH_DOT);
                    default: add_name($urandom_range(1, 8));
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                path_q.push_back(CH_SLASH);
        end
    endtask

    // ------------------------------------------------------------------------
    // configuration port: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr && addr == ROOT_ADDR) begin
            root_len = data[FIELD_W-1:0];
            root_settings++;
        end
        if (!wr && prdata !== {{(32 - FIELD_W){1'b0}}, root_len}) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: root_length read back 0x%08h, expected 0x%08h",
                         $realtime, prdata, {{(32 - FIELD_W){1'b0}}, root_len});
            mismatches++;
        end
        // return to idle between transfers
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // block is idle once every descriptor is out and the settle time has passed
    task automatic wait_idle(input int settle);
        i_valid <= 1'b0;
        while (seg_expect_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: ready follows a rotating stall pattern
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready  <= stall_pat[stall_ph];
        stall_ph <= stall_ph + 1'b1;
    end

    // ------------------------------------------------------------------------
    // descriptor checker: every transfer against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : desc_check
        seg_desc_t got;
        seg_desc_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got.seg_off  = o_segment_offset;
            got.seg_len  = o_segment_length;
            got.no_seg   = o_no_segments;
            got.too_long = o_too_long;
            got.ovf      = o_stack_overflow;
            got.last_seg = o_last_segment;
            descs_seen++;
            if (seg_expect_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected descriptor off=%0d len=%0d none=%b tl=%b ov=%b last=%b",
                             $realtime, got.seg_off, got.seg_len, got.no_seg,
                             got.too_long, got.ovf, got.last_seg);
                mismatches++;
            end else begin
                want = seg_expect_q.pop_front();
                if (got !== want) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: descriptor mismatch", $realtime);
                        $display("  expected off=%0d len=%0d none=%b tl=%b ov=%b last=%b",
                                 want.seg_off, want.seg_len, want.no_seg,
                                 want.too_long, want.ovf, want.last_seg);
                        $display("  actual   off=%0d len=%0d none=%b tl=%b ov=%b last=%b",
                                 got.seg_off, got.seg_len, got.no_seg,
                                 got.too_long, got.ovf, got.last_seg);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any transfer on any port counts as progress
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int          phase_start;
        logic [11:0] root_plan [NUM_PHASES];
        int          gap_plan  [NUM_PHASES];

        // every input known from time zero
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_path_byte   = '0;
        i_end_of_path = 1'b0;
        i_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        stall_pat     = '1;
        stall_ph      = '0;
        mismatches    = 0;
        paths_sent    = 0;
        bytes_sent    = 0;
        descs_seen    = 0;
        ovf_runs      = 0;
        too_long_runs = 0;
        url_long_runs = 0;
        root_settings = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        gap_max       = 3;
        root_len      = '0;
        clear_path();

        // extremes first, random values and near-extremes after them
        root_plan = '{12'd4095, 12'd0, 12'($urandom_range(1, 4094)), 12'd4094,
                      12'($urandom_range(0, 4095)), 12'd1};
        // zero entries give stretches with back-to-back bytes
        gap_plan  = '{3, 0, 8, 2, 0, 5};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, root_length still at its reset value
        for (int r = 0; r < DIR_ROWS; r++)
            push_byte(DIR_TAB[r].byte_val, DIR_TAB[r].eop, DIR_TAB[r].typed, DIR_TAB[r].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle(SETTLE_CYCLES);
            gap_max = gap_plan[ph];
            // upper data bits are random, only the low twelve land
            apb_access(1'b1, ROOT_ADDR, {20'($urandom), root_plan[ph]});
            if (ph == 2)
                apb_access(1'b1, SPARE_ADDR, $urandom);   // unmapped, no effect
            apb_access(1'b0, ROOT_ADDR, '0);
            stall_pat <= (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_path(1'b0);
                send_path();
            end
        end

        wait_idle(TAIL_CYCLES);
        if (seg_expect_q.size() != 0) begin
            $display("%0d descriptors never arrived", seg_expect_q.size());
            mismatches += seg_expect_q.size();
        end

        $display("covered %0d paths (%0d bytes) and %0d descriptors over %0d root_length values",
                 paths_sent, bytes_sent, descs_seen, root_settings);
        $display("runs with stack overflow %0d, flagged too long %0d, past byte 4095 %0d",
                 ovf_runs, too_long_runs, url_long_runs);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/udsn_pkg.sv
rtl/udsn_ctrl.sv
rtl/udsn_datapath.sv
rtl/url_path_dot_segment_normalizer_top.sv
verif/tb_url_path_dot_segment_normalizer_top.sv
